### hdl/assert_macros.svh
// Assertion macros shared by the crossing controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define PCC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define PCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/pcc_pkg.sv
// Types, constants and lamp decoding for the crossing controller
package pcc_pkg;

   localparam int TIMER_BITS = 16;
   localparam int DUR_W      = 16;
   localparam int FLASH_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_STARTUP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YELLOW     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_HOLD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WALK       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_HALF = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_CNT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN   = 3'd6;

   localparam logic [DUR_W-1:0]   RST_STARTUP    = 16'd5000;
   localparam logic [DUR_W-1:0]   RST_YELLOW     = 16'd3000;
   localparam logic [DUR_W-1:0]   RST_RED_HOLD   = 16'd2000;
   localparam logic [DUR_W-1:0]   RST_WALK       = 16'd4000;
   localparam logic [DUR_W-1:0]   RST_FLASH_HALF = 16'd500;
   localparam logic [FLASH_W-1:0] RST_FLASH_CNT  = 4'd8;
   localparam logic [DUR_W-1:0]   RST_COOLDOWN   = 16'd5000;

   localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

   typedef enum logic [8:0] {
      PH_STARTUP   = 9'b000000001,
      PH_TO_GREEN  = 9'b000000010,
      PH_GREEN     = 9'b000000100,
      PH_TO_RED    = 9'b000001000,
      PH_RED_HOLD  = 9'b000010000,
      PH_WALK      = 9'b000100000,
      PH_FLASH_ON  = 9'b001000000,
      PH_FLASH_OFF = 9'b010000000,
      PH_COOLDOWN  = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [DUR_W-1:0]   startup_ms;
      logic [DUR_W-1:0]   yellow_ms;
      logic [DUR_W-1:0]   red_hold_ms;
      logic [DUR_W-1:0]   walk_ms;
      logic [DUR_W-1:0]   flash_half_ms;
      logic [FLASH_W-1:0] flash_count;
      logic [DUR_W-1:0]   cooldown_ms;
   } cfg_type;

   typedef struct packed {
      logic road_red;
      logic road_yellow;
      logic road_green;
      logic walk_red;
      logic walk_green;
      logic button_led;
   } lamps_type;

   function automatic logic [TIMER_BITS-1:0] phase_len(input logic [DUR_W-1:0] dur);
      logic [32:0] v;
      v = 33'(dur);
      if (v == 33'd0) v = 33'd1;
      if (v > TIMER_MAX) v = TIMER_MAX;
      return v[TIMER_BITS-1:0];
   endfunction

   function automatic lamps_type phase_lamps(input phase_type ph, input logic button);
      lamps_type l;
      l = '0;
      l.button_led = button;
      case (ph)
         PH_STARTUP: begin
            l.road_red = 1'b1; l.walk_red = 1'b1;
         end
         PH_TO_GREEN: begin
            l.road_red = 1'b1; l.road_yellow = 1'b1; l.walk_red = 1'b1;
         end
         PH_TO_RED: begin
            l.road_yellow = 1'b1; l.walk_red = 1'b1;
         end
         PH_RED_HOLD: begin
            l.road_red = 1'b1; l.walk_red = 1'b1;
         end
         PH_WALK: begin
            l.road_red = 1'b1; l.walk_green = 1'b1;
         end
         PH_FLASH_ON: begin
            l.road_yellow = 1'b1; l.walk_green = 1'b1;
         end
         PH_FLASH_OFF: begin
            l.road_red = 1'b0;
         end
         default: begin
            l.road_green = 1'b1; l.walk_red = 1'b1;
         end
      endcase
      return l;
   endfunction

endpackage

### hdl/pedestrian_crossing_controller_core.sv
// Pelican crossing controller: top level
//
// One req_ beat per millisecond tick carries the sampled push button
// (req_button). For each beat one rsp_ beat returns the six lamp states
// shown during that tick: road red, yellow and green, crossing red and
// green, and button_led, which mirrors the button of that tick.
// An accepted beat's result is registered in the result register, or in
// the skid stage if that holds a stalled result. Throughput: one beat per
// cycle unless req_stall; phase, timer and request latch step per beat.
// req_stall rises only when both the result register and the skid stage
// hold beats; a stalled result holds on rsp_ and one more beat is taken
// into the skid stage meanwhile.
// The csr_ port writes the seven timing registers (index 0 start-up,
// 1 yellow, 2 red hold, 3 walk, 4 flash half period, 5 flash count,
// 6 cooldown); write them only while the block is idle.
// Synchronous reset restores the register defaults, empties the result
// path and starts in the start-up red phase with no request latched.
`include "assert_macros.svh"

module pedestrian_crossing_controller_core
   import pcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_button,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_road_red,
   output logic                  rsp_road_yellow,
   output logic                  rsp_road_green,
   output logic                  rsp_walk_red,
   output logic                  rsp_walk_green,
   output logic                  rsp_button_led,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type   cfg;
   lamps_type lamps;
   lamps_type rsp_lamps;
   logic      accept;
   logic      full;

   assign req_stall = full;
   assign accept    = req_valid & ~full;

   pcc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   pcc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .button (req_button),
      .cfg    (cfg),
      .lamps  (lamps)
   );

   pcc_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (lamps),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_lamps)
   );

   assign rsp_road_red    = rsp_lamps.road_red;
   assign rsp_road_yellow = rsp_lamps.road_yellow;
   assign rsp_road_green  = rsp_lamps.road_green;
   assign rsp_walk_red    = rsp_lamps.walk_red;
   assign rsp_walk_green  = rsp_lamps.walk_green;
   assign rsp_button_led  = rsp_lamps.button_led;

   `PCC_ASSERT_IMPL(a_stall_needs_result, clock, reset, req_stall, rsp_valid, "stall with empty result register")
   `PCC_ASSERT_NEXT(a_accept_gives_result, clock, reset, req_valid && !req_stall, rsp_valid, "accepted beat produced no result")
   `PCC_ASSERT_IMPL(a_no_conflict, clock, reset, rsp_valid, !(rsp_road_green && rsp_walk_green), "road green together with crossing green")

endmodule

### hdl/pcc_csr.sv
// Timing configuration registers of the crossing controller
module pcc_csr
   import pcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_STARTUP:    cfg_in.startup_ms    = csr_data[DUR_W-1:0];
            CSR_YELLOW:     cfg_in.yellow_ms     = csr_data[DUR_W-1:0];
            CSR_RED_HOLD:   cfg_in.red_hold_ms   = csr_data[DUR_W-1:0];
            CSR_WALK:       cfg_in.walk_ms       = csr_data[DUR_W-1:0];
            CSR_FLASH_HALF: cfg_in.flash_half_ms = csr_data[DUR_W-1:0];
            CSR_FLASH_CNT:  cfg_in.flash_count   = csr_data[FLASH_W-1:0];
            CSR_COOLDOWN:   cfg_in.cooldown_ms   = csr_data[DUR_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.startup_ms    <= RST_STARTUP;
         cfg_ff.yellow_ms     <= RST_YELLOW;
         cfg_ff.red_hold_ms   <= RST_RED_HOLD;
         cfg_ff.walk_ms       <= RST_WALK;
         cfg_ff.flash_half_ms <= RST_FLASH_HALF;
         cfg_ff.flash_count   <= RST_FLASH_CNT;
         cfg_ff.cooldown_ms   <= RST_COOLDOWN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/pcc_seq.sv
// Phase sequencer: phase, phase timer, flash counter and request latch
module pcc_seq
   import pcc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  logic      button,
   input  cfg_type   cfg,
   output lamps_type lamps
);

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [FLASH_W-1:0]    flashes_ff, flashes_in;
   logic                  request_ff, request_in;

   logic                  pending;
   logic                  timed;
   logic [DUR_W-1:0]      dur;
   logic [TIMER_BITS-1:0] len;
   logic [TIMER_BITS-1:0] timer_inc;
   logic [FLASH_W-1:0]    flashes_dec;

   assign pending     = request_ff | button;
   assign timer_inc   = timer_ff + 1'b1;
   assign flashes_dec = flashes_ff - 1'b1;
   assign len         = phase_len(dur);
   assign lamps       = phase_lamps(phase_ff, button);

   always_comb begin
      timed = 1'b1;
      dur   = '0;
      case (phase_ff)
         PH_STARTUP:   dur = cfg.startup_ms;
         PH_TO_GREEN:  dur = cfg.yellow_ms;
         PH_TO_RED:    dur = cfg.yellow_ms;
         PH_RED_HOLD:  dur = cfg.red_hold_ms;
         PH_WALK:      dur = cfg.walk_ms;
         PH_FLASH_ON:  dur = cfg.flash_half_ms;
         PH_FLASH_OFF: dur = cfg.flash_half_ms;
         PH_COOLDOWN:  dur = cfg.cooldown_ms;
         default:      timed = 1'b0;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      timer_in   = timer_ff;
      flashes_in = flashes_ff;
      request_in = pending;
      if (!timed) begin
         phase_in = PH_GREEN;
         if (pending) begin
            phase_in = PH_TO_RED;
            timer_in = '0;
         end
      end else if (timer_inc < len) begin
         timer_in = timer_inc;
      end else begin
         timer_in = '0;
         case (phase_ff)
            PH_STARTUP:  phase_in = PH_TO_GREEN;
            PH_TO_GREEN: phase_in = PH_GREEN;
            PH_TO_RED:   phase_in = PH_RED_HOLD;
            PH_RED_HOLD: phase_in = PH_WALK;
            PH_WALK: begin
               flashes_in = cfg.flash_count;
               if (cfg.flash_count == '0) begin
                  phase_in   = PH_COOLDOWN;
                  request_in = 1'b0;
               end else begin
                  phase_in = PH_FLASH_ON;
               end
            end
            PH_FLASH_ON: phase_in = PH_FLASH_OFF;
            PH_FLASH_OFF: begin
               flashes_in = flashes_dec;
               if (flashes_dec == '0) begin
                  phase_in   = PH_COOLDOWN;
                  request_in = 1'b0;
               end else begin
                  phase_in = PH_FLASH_ON;
               end
            end
            default: phase_in = PH_GREEN;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_STARTUP;
         timer_ff   <= '0;
         flashes_ff <= '0;
         request_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         timer_ff   <= timer_in;
         flashes_ff <= flashes_in;
         request_ff <= request_in;
      end
   end

endmodule

### hdl/pcc_out_buf.sv
// Result register with a skid stage on the lamp channel
module pcc_out_buf
   import pcc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  lamps_type push_data,
   output logic      full,
   output logic      out_valid,
   input  logic      out_stall,
   output lamps_type out_data
);

   logic      main_valid_ff, main_valid_in;
   logic      skid_valid_ff, skid_valid_in;
   lamps_type main_ff, main_in;
   lamps_type skid_ff, skid_in;
   logic      take;

   assign take = main_valid_ff & ~out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !take) begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

### tb/tb.sv
// Self-checking testbench for the pelican crossing controller core
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pcc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_TICKS = 24;
   localparam bit [0:DIRECTED_TICKS-1] DIRECTED_PRESSES = 24'b1000_0010_0110_0000_0001_0000;
   localparam int SETTING_COUNT = 10;
   localparam int TICKS_PER_SETTING = 58;
   localparam int PRESSURE_SETTING = 5;
   localparam int HOLD_OFF_CYCLES = 60;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   class crossing_scoreboard;
      cfg_type               cfg;
      phase_type             cur_phase;
      logic [TIMER_BITS-1:0] tick_count;
      logic [FLASH_W-1:0]    flashes_left;
      bit                    crossing_requested;
      lamps_type             expected_lamps[$];
      int                    errors;
      int                    ticks_seen;
      int                    results_checked;

      function new();
         cfg.startup_ms     = RST_STARTUP;
         cfg.yellow_ms      = RST_YELLOW;
         cfg.red_hold_ms    = RST_RED_HOLD;
         cfg.walk_ms        = RST_WALK;
         cfg.flash_half_ms  = RST_FLASH_HALF;
         cfg.flash_count    = RST_FLASH_CNT;
         cfg.cooldown_ms    = RST_COOLDOWN;
         cur_phase          = PH_STARTUP;
         tick_count         = '0;
         flashes_left       = '0;
         crossing_requested = 1'b0;
         errors             = 0;
         ticks_seen         = 0;
         results_checked    = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_STARTUP:    cfg.startup_ms    = data;
            CSR_YELLOW:     cfg.yellow_ms     = data;
            CSR_RED_HOLD:   cfg.red_hold_ms   = data;
            CSR_WALK:       cfg.walk_ms       = data;
            CSR_FLASH_HALF: cfg.flash_half_ms = data;
            CSR_FLASH_CNT:  cfg.flash_count   = data[FLASH_W-1:0];
            CSR_COOLDOWN:   cfg.cooldown_ms   = data;
            default: ;
         endcase
      endfunction

      function void enter(input phase_type p);
         cur_phase  = p;
         tick_count = '0;
      endfunction

      function void start_cooldown();
         enter(PH_COOLDOWN);
         crossing_requested = 1'b0;
      endfunction

      function lamps_type predict_lamps(input bit button);
         lamps_type        l;
         logic [4:0]       lit;
         logic [DUR_W-1:0] dur;
         if (button) crossing_requested = 1'b1;
         case (cur_phase)
            PH_STARTUP, PH_RED_HOLD: lit = 5'b10010;
            PH_TO_GREEN:             lit = 5'b11010;
            PH_TO_RED:               lit = 5'b01010;
            PH_WALK:                 lit = 5'b10001;
            PH_FLASH_ON:             lit = 5'b01001;
            PH_FLASH_OFF:            lit = 5'b00000;
            default:                 lit = 5'b00110;
         endcase
         {l.road_red, l.road_yellow, l.road_green, l.walk_red, l.walk_green} = lit;
         l.button_led = button;
         case (cur_phase)
            PH_STARTUP:                dur = cfg.startup_ms;
            PH_TO_GREEN, PH_TO_RED:    dur = cfg.yellow_ms;
            PH_RED_HOLD:               dur = cfg.red_hold_ms;
            PH_WALK:                   dur = cfg.walk_ms;
            PH_FLASH_ON, PH_FLASH_OFF: dur = cfg.flash_half_ms;
            PH_COOLDOWN:               dur = cfg.cooldown_ms;
            default: begin
               if (crossing_requested) enter(PH_TO_RED);
               return l;
            end
         endcase
         tick_count = tick_count + 1'b1;
         if (dur == '0) dur = 16'd1;
         if (tick_count < dur) return l;
         case (cur_phase)
            PH_STARTUP:  enter(PH_TO_GREEN);
            PH_TO_GREEN: enter(PH_GREEN);
            PH_TO_RED:   enter(PH_RED_HOLD);
            PH_RED_HOLD: enter(PH_WALK);
            PH_WALK: begin
               flashes_left = cfg.flash_count;
               if (flashes_left == '0) start_cooldown();
               else enter(PH_FLASH_ON);
            end
            PH_FLASH_ON: enter(PH_FLASH_OFF);
            PH_FLASH_OFF: begin
               flashes_left = flashes_left - 1'b1;
               if (flashes_left == '0) start_cooldown();
               else enter(PH_FLASH_ON);
            end
            default: enter(PH_GREEN);
         endcase
         return l;
      endfunction

      function void note_tick(input bit button);
         expected_lamps.push_back(predict_lamps(button));
         ticks_seen++;
      endfunction

      function void compare_lamp(input string name, input logic want, input logic got);
         if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            errors++;
         end
      endfunction

      function void check_lamps(input lamps_type got);
         lamps_type want;
         if (expected_lamps.size() == 0) begin
            $error("lamp beat arrived with no tick outstanding");
            errors++;
            return;
         end
         want = expected_lamps.pop_front();
         results_checked++;
         compare_lamp("road_red", want.road_red, got.road_red);
         compare_lamp("road_yellow", want.road_yellow, got.road_yellow);
         compare_lamp("road_green", want.road_green, got.road_green);
         compare_lamp("walk_red", want.walk_red, got.walk_red);
         compare_lamp("walk_green", want.walk_green, got.walk_green);
         compare_lamp("button_led", want.button_led, got.button_led);
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_button = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_road_red;
   logic                  rsp_road_yellow;
   logic                  rsp_road_green;
   logic                  rsp_walk_red;
   logic                  rsp_walk_green;
   logic                  rsp_button_led;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   crossing_scoreboard sb = new();
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          hold_req = 1'b0;
   bit          holding = 1'b0;

   pedestrian_crossing_controller_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_button       (req_button),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_road_red     (rsp_road_red),
      .rsp_road_yellow  (rsp_road_yellow),
      .rsp_road_green   (rsp_road_green),
      .rsp_walk_red     (rsp_walk_red),
      .rsp_walk_green   (rsp_walk_green),
      .rsp_button_led   (rsp_button_led),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_tick(input bit button);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_button <= button;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_tick(button);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic apply_settings(input cfg_type c);
      write_csr(CSR_STARTUP, c.startup_ms);
      write_csr(CSR_YELLOW, c.yellow_ms);
      write_csr(CSR_RED_HOLD, c.red_hold_ms);
      write_csr(CSR_WALK, c.walk_ms);
      write_csr(CSR_FLASH_HALF, c.flash_half_ms);
      write_csr(CSR_FLASH_CNT, {12'($urandom_range(0, 4095)), c.flash_count});
      write_csr(CSR_COOLDOWN, c.cooldown_ms);
      write_csr(CSR_UNUSED, 16'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain_lamps();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_lamps.size() != 0) @(posedge clock);
   endtask

   function automatic cfg_type make_settings(input int k);
      cfg_type c;
      c.startup_ms    = 16'($urandom_range(0, 6));
      c.yellow_ms     = 16'($urandom_range(0, 6));
      c.red_hold_ms   = 16'($urandom_range(0, 6));
      c.walk_ms       = 16'($urandom_range(0, 6));
      c.flash_half_ms = 16'($urandom_range(0, 3));
      c.flash_count   = 4'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 15 : 3));
      c.cooldown_ms   = 16'($urandom_range(0, 8));
      case (k)
         1: begin
            c = '0;
            c.startup_ms    = 16'd1;
            c.yellow_ms     = 16'd1;
            c.red_hold_ms   = 16'd1;
            c.walk_ms       = 16'd1;
            c.flash_half_ms = 16'd1;
            c.cooldown_ms   = 16'd1;
            c.flash_count   = 4'hF;
         end
         2: c = '0;
         3: begin
            c.startup_ms  = 16'hFFFF;
            c.yellow_ms   = 16'hFFFF;
            c.walk_ms     = 16'hFFFF;
            c.cooldown_ms = 16'hFFFF;
         end
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      wait (hold_req);
      holding <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   always @(posedge clock) begin
      lamps_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.road_red    = rsp_road_red;
         seen.road_yellow = rsp_road_yellow;
         seen.road_green  = rsp_road_green;
         seen.walk_red    = rsp_walk_red;
         seen.walk_green  = rsp_walk_green;
         seen.button_led  = rsp_button_led;
         sb.check_lamps(seen);
      end
      if (holding) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      cfg_type       c;
      idle_mode_type mode;
      int unsigned   press_pct;
      int unsigned   press_choices[4];
      press_choices = '{2, 10, 40, 80};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      c.startup_ms    = 16'd2;
      c.yellow_ms     = 16'd0;
      c.red_hold_ms   = 16'd1;
      c.walk_ms       = 16'd2;
      c.flash_half_ms = 16'd1;
      c.flash_count   = 4'd1;
      c.cooldown_ms   = 16'd3;
      apply_settings(c);
      for (int i = 0; i < DIRECTED_TICKS; i++) send_tick(DIRECTED_PRESSES[i]);
      drain_lamps();

      for (int k = 0; k < SETTING_COUNT; k++) begin
         apply_settings(make_settings(k));
         mode = idle_mode_type'(k % 4);
         if (k == PRESSURE_SETTING) mode = IDLE_NONE;
         case (mode)
            IDLE_SENDER:   begin send_idle_pct = 70; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            IDLE_BOTH:     begin send_idle_pct = 26; recv_stall_pct = 26; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         endcase
         if (k == PRESSURE_SETTING) hold_req = 1'b1;
         press_pct = press_choices[$urandom_range(0, 3)];
         repeat (TICKS_PER_SETTING) send_tick($urandom_range(0, 99) < press_pct);
         drain_lamps();
      end

      recv_stall_pct = 0;
      repeat (8) @(posedge clock);
      $display("summary: %0d ticks sent, %0d lamp beats checked, over %0d timing settings",
               sb.ticks_seen, sb.results_checked, SETTING_COUNT + 1);
      $display("summary: covered gaps, stalls and a long output hold-off");
      if (sb.errors == 0 && sb.expected_lamps.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
